FILE: hdl/dspv_pkg.sv
`default_nettype none

package dspv_pkg;

  localparam int CHAR_W  = 8;
  localparam int POS_W   = 4;
  localparam int DAY_W   = 7;
  localparam int MONTH_W = 7;
  localparam int YEAR_W  = 14;
  localparam int DIGIT_W = 4;

  localparam logic [CHAR_W-1:0] CODE_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CODE_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] CODE_SLASH = 8'd47;

  // character positions in DD/MM/YYYY
  localparam logic [POS_W-1:0] POS_DAY_HI   = 4'd0;
  localparam logic [POS_W-1:0] POS_DAY_LO   = 4'd1;
  localparam logic [POS_W-1:0] POS_SLASH_A  = 4'd2;
  localparam logic [POS_W-1:0] POS_MON_HI   = 4'd3;
  localparam logic [POS_W-1:0] POS_MON_LO   = 4'd4;
  localparam logic [POS_W-1:0] POS_SLASH_B  = 4'd5;
  localparam logic [POS_W-1:0] POS_YEAR_0   = 4'd6;
  localparam logic [POS_W-1:0] POS_YEAR_1   = 4'd7;
  localparam logic [POS_W-1:0] POS_YEAR_2   = 4'd8;
  localparam logic [POS_W-1:0] POS_LAST     = 4'd9;
  localparam logic [POS_W-1:0] POS_SAT      = 4'd11;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 7'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 7'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 7'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 7'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 7'd11;
  localparam logic [MONTH_W-1:0] MONTH_MAX = 7'd12;

  localparam logic [DAY_W-1:0] DAY_MAX_LONG  = 7'd31;
  localparam logic [DAY_W-1:0] DAY_MAX_SHORT = 7'd30;
  localparam logic [DAY_W-1:0] DAY_MAX_FEB   = 7'd29;

  localparam int OUT_W = 32;

  typedef struct packed {
    logic               format_ok;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } parse_res_t;

endpackage

`default_nettype wire

FILE: hdl/dspv_parse.sv
`default_nettype none

module dspv_parse
  import dspv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire logic              last_char,
  output parse_res_t             res
);

  logic [POS_W-1:0]   position, position_next;
  logic               layout_good, layout_good_next;
  logic [DAY_W-1:0]   day_acc, day_acc_next;
  logic [MONTH_W-1:0] month_acc, month_acc_next;
  logic [YEAR_W-1:0]  year_acc, year_acc_next;

  logic               digit;
  logic [DIGIT_W-1:0] dval;
  logic               fmt;

  assign digit = (char_code >= CODE_ZERO) && (char_code <= CODE_NINE);
  // '0' is 0x30, so the low nibble is the digit value
  assign dval  = char_code[DIGIT_W-1:0];

  always_comb begin
    layout_good_next = layout_good;
    day_acc_next     = day_acc;
    month_acc_next   = month_acc;
    year_acc_next    = year_acc;
    unique case (position) inside
      POS_SLASH_A, POS_SLASH_B: begin
        if (char_code != CODE_SLASH) layout_good_next = 1'b0;
      end
      POS_DAY_HI, POS_DAY_LO: begin
        if (!digit) layout_good_next = 1'b0;
        else day_acc_next = {day_acc[DAY_W-4:0], 3'b000} + {day_acc[DAY_W-2:0], 1'b0}
                            + DAY_W'(dval);
      end
      POS_MON_HI, POS_MON_LO: begin
        if (!digit) layout_good_next = 1'b0;
        else month_acc_next = {month_acc[MONTH_W-4:0], 3'b000}
                              + {month_acc[MONTH_W-2:0], 1'b0} + MONTH_W'(dval);
      end
      POS_YEAR_0, POS_YEAR_1, POS_YEAR_2, POS_LAST: begin
        if (!digit) layout_good_next = 1'b0;
        else year_acc_next = {year_acc[YEAR_W-4:0], 3'b000}
                             + {year_acc[YEAR_W-2:0], 1'b0} + YEAR_W'(dval);
      end
      default: layout_good_next = 1'b0;  // past the tenth character
    endcase
    position_next = (position < POS_SAT) ? position + 1'b1 : position;
  end

  assign fmt           = layout_good_next && (position == POS_LAST);
  assign res.format_ok = fmt;
  assign res.day       = fmt ? day_acc_next   : '0;
  assign res.month     = fmt ? month_acc_next : '0;
  assign res.year      = fmt ? year_acc_next  : '0;

  always_ff @(posedge clk) begin
    if (rst || (step && last_char)) begin
      position    <= '0;
      layout_good <= 1'b1;
      day_acc     <= '0;
      month_acc   <= '0;
      year_acc    <= '0;
    end else if (step) begin
      position    <= position_next;
      layout_good <= layout_good_next;
      day_acc     <= day_acc_next;
      month_acc   <= month_acc_next;
      year_acc    <= year_acc_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dspv_calendar.sv
`default_nettype none

module dspv_calendar
  import dspv_pkg::*;
(
  input  wire logic [DAY_W-1:0]   day,
  input  wire logic [MONTH_W-1:0] month,
  input  wire logic [YEAR_W-1:0]  year,
  output logic                    ok
);

  logic short_month;

  assign short_month = (month == MONTH_APR) || (month == MONTH_JUN) ||
                       (month == MONTH_SEP) || (month == MONTH_NOV);

  always_comb begin
    ok = 1'b1;
    if (day == '0 || month == '0) ok = 1'b0;
    if (month > MONTH_MAX || day > DAY_MAX_LONG) ok = 1'b0;
    if (short_month && day > DAY_MAX_SHORT) ok = 1'b0;
    if (month == MONTH_FEB && day > DAY_MAX_FEB) ok = 1'b0;
    // leap day only when year is a multiple of four
    if (month == MONTH_FEB && day == DAY_MAX_FEB && year[1:0] != 2'b00) ok = 1'b0;
  end

endmodule

`default_nettype wire

FILE: hdl/date_string_parse_validate.sv
// Channel  Dir  Bits  Contents (lowest bit up)
// s_*      in   8+1   tdata: char_code[7:0]; tlast: last_char
// m_*      out  32    tdata: format_ok, date_valid, day[6:0], month[6:0],
//                     year[13:0], 2 zero pad bits
//
// One character word per cycle is taken, except while a last character
// waits for the result register. The result word of a text passes through the
// input register, then the parse/calendar logic into the result register.
// Synchronous reset clears the input and result valids and the parse state.
// Non-last characters move on even while a result waits; only a last
// character holds in the input register until the result register is free.
`default_nettype none

module date_string_parse_validate
  import dspv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [CHAR_W-1:0] s_tdata,   // char_code[7:0]
  input  wire logic              s_tlast,   // last_char
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [OUT_W-1:0]       m_tdata    // format_ok, date_valid, day, month, year
);

  // input register
  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;

  logic       out_free;   // result register can take a new word
  logic       consume;    // input register word is processed this cycle
  parse_res_t res;
  logic       cal_ok;

  assign out_free = !m_tvalid || m_tready;
  assign consume  = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  dspv_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (consume),
    .char_code (in_char),
    .last_char (in_last),
    .res       (res)
  );

  dspv_calendar u_calendar (
    .day   (res.day),
    .month (res.month),
    .year  (res.year),
    .ok    (cal_ok)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= consume && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && in_last) begin
      m_tdata <= {2'b00, res.year, res.month, res.day,
                  res.format_ok && cal_ok, res.format_ok};
    end
  end

`ifndef NO_ASSERTIONS
  // a processed last character always yields a result word
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    consume && in_last |=> m_tvalid)
    else $error("last character did not produce a result");

  // a last character is never dropped while the result is stalled
  a_last_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_last && m_tvalid && !m_tready |=> in_valid && in_last)
    else $error("last character lost under stall");

  // a valid date needs a good layout
  a_valid_needs_fmt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[0])
    else $error("date_valid without format_ok");

  // bad layout reports zero fields
  a_bad_fmt_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[OUT_W-1:2] == '0)
    else $error("fields nonzero with bad format");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_date_string_parse_validate.sv
`timescale 1ns / 1ps

module tb_date_string_parse_validate
  import dspv_pkg::*;
;

  // Result word as it sits on m_tdata, lowest bit last in the list.
  typedef struct packed {
    logic [1:0]         pad;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               valid;
    logic               fmt_ok;
  } date_word_t;

  localparam int PREDICT  = -1;  // table row checked against the predictor only
  localparam int DIR_N    = 28;
  localparam int PHASE_CH = 450; // random phase ph runs until (ph+1) times this many characters are sent
  localparam int HOLD_LEN = 120; // long receiver hold, in cycles

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [CHAR_W-1:0] s_tdata;   // char_code[7:0]
  logic              s_tlast;   // last_char
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;   // format_ok, date_valid, day, month, year, pad

  date_word_t pending_dates [$];
  int         fails    = 0;
  int         src_idle = 0;     // percent of cycles the sender idles
  int         snk_idle = 0;     // percent of cycles the receiver idles
  bit         hold_go  = 1'b0;  // asks the receiver for one long hold

  // Predictor copy of the parse state.
  logic [POS_W-1:0]   txt_pos  = '0;
  bit                 txt_good = 1'b1;
  logic [DAY_W-1:0]   day_sum  = '0;
  logic [MONTH_W-1:0] mon_sum  = '0;
  logic [YEAR_W-1:0]  yr_sum   = '0;

  // Directed texts. '#' stands for character code 0, which a string can't hold.
  string dir_txt [DIR_N] = '{
    "01/01/0000", "31/12/9999", "99/99/9999", "00/05/2020", "15/00/2020",
    "00/00/0000", "29/02/2024", "29/02/2023", "29/02/0000", "30/02/2024",
    "31/04/2021", "31/06/2021", "31/09/2021", "31/11/2021", "30/11/2021",
    "31/13/2000", "32/01/2000", "5",          "1/01/2000",  "01/01/20000",
    "01/01/2000xyzw", "01-01/2000", "01/01/2:00", "01/01/2/00", "#1/01/2000",
    "01/01/19\3779", "28/02/1999", "17/08/1987"
  };

  // format_ok, date_valid, day, month, year
  int dir_want [DIR_N][5] = '{
    '{1, 1, 1, 1, 0},      // year zero is accepted
    '{1, 1, 31, 12, 9999},
    '{1, 0, 99, 99, 9999},
    '{1, 0, 0, 5, 2020},   // day zero
    '{1, 0, 15, 0, 2020},  // month zero
    '{1, 0, 0, 0, 0},
    '{1, 1, 29, 2, 2024},
    '{1, 0, 29, 2, 2023},  // leap day off a leap year
    '{1, 1, 29, 2, 0},
    '{1, 0, 30, 2, 2024},
    '{1, 0, 31, 4, 2021},  // 30-day months
    '{1, 0, 31, 6, 2021},
    '{1, 0, 31, 9, 2021},
    '{1, 0, 31, 11, 2021},
    '{1, 1, 30, 11, 2021},
    '{1, 0, 31, 13, 2000},
    '{1, 0, 32, 1, 2000},
    '{0, 0, 0, 0, 0},      // too short
    '{0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0},      // too long
    '{0, 0, 0, 0, 0},      // too long, position saturates
    '{0, 0, 0, 0, 0},      // wrong separator
    '{0, 0, 0, 0, 0},      // code just above '9'
    '{0, 0, 0, 0, 0},      // code just below '0'
    '{0, 0, 0, 0, 0},      // code 0 is no terminator
    '{0, 0, 0, 0, 0},      // code 255
    '{PREDICT, 0, 0, 0, 0},
    '{PREDICT, 0, 0, 0, 0}
  };

  date_string_parse_validate i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Steps the predictor on one accepted character. Returns 1 when the
  // character closes a text, with the expected result word in w.
  function automatic bit parse_char(input logic [CHAR_W-1:0] c, input logic l,
                                    output date_word_t w);
    logic [POS_W-1:0] p;
    bit               is_dig;
    logic [3:0]       dv;
    p      = txt_pos;
    is_dig = (c >= CODE_ZERO) && (c <= CODE_NINE);
    dv     = is_dig ? 4'(c - CODE_ZERO) : 4'd0;
    w      = '0;
    if (p <= POS_LAST) begin
      if (p == POS_SLASH_A || p == POS_SLASH_B) begin
        if (c != CODE_SLASH) txt_good = 1'b0;
      end else if (!is_dig) begin
        txt_good = 1'b0;
      end else if (p <= POS_DAY_LO) begin
        day_sum = DAY_W'(day_sum * 10 + dv);
      end else if (p <= POS_MON_LO) begin
        mon_sum = MONTH_W'(mon_sum * 10 + dv);
      end else begin
        yr_sum = YEAR_W'(yr_sum * 10 + dv);
      end
    end else begin
      txt_good = 1'b0;  // anything past the tenth character
    end
    if (txt_pos < POS_SAT) txt_pos = txt_pos + 1'b1;
    if (!l) return 1'b0;

    if (txt_good && p == POS_LAST) begin
      w.fmt_ok = 1'b1;
      w.day    = day_sum;
      w.month  = mon_sum;
      w.year   = yr_sum;
      // calendar rules
      w.valid  = day_sum != 0 && mon_sum != 0 && mon_sum <= MONTH_MAX &&
                 day_sum <= DAY_MAX_LONG;
      if ((mon_sum == MONTH_APR || mon_sum == MONTH_JUN || mon_sum == MONTH_SEP ||
           mon_sum == MONTH_NOV) && day_sum > DAY_MAX_SHORT)
        w.valid = 1'b0;
      if (mon_sum == MONTH_FEB && day_sum > DAY_MAX_FEB) w.valid = 1'b0;
      if (mon_sum == MONTH_FEB && day_sum == DAY_MAX_FEB && yr_sum % 4 != 0)
        w.valid = 1'b0;
    end
    txt_pos  = '0;
    txt_good = 1'b1;
    day_sum  = '0;
    mon_sum  = '0;
    yr_sum   = '0;
    return 1'b1;
  endfunction

  // Offers one character word; called and left at a falling edge.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic l,
                           input bit tab_on, input date_word_t tab_w);
    date_word_t w;
    if (src_idle != 0 && $urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= l;
    do @(posedge clk); while (!s_tready);
    if (parse_char(c, l, w)) pending_dates.push_back(tab_on ? tab_w : w);
    @(negedge clk);
  endtask

  task automatic send_text(input logic [CHAR_W-1:0] t [$], input bit tab_on,
                           input date_word_t tab_w);
    for (int i = 0; i < t.size(); i++)
      send_char(t[i], i == t.size() - 1, tab_on, tab_w);
  endtask

  // Mostly well-formed dates with random digits, biased toward the edges of
  // the calendar; the rest is corrupted, cut short, run long or pure noise.
  task automatic make_text(ref logic [CHAR_W-1:0] t [$]);
    int unsigned d, m, y, kind, n;
    d = ($urandom_range(99) < 70) ? $urandom_range(1, 31) : $urandom_range(0, 99);
    m = ($urandom_range(99) < 75) ? $urandom_range(1, 12) : $urandom_range(0, 99);
    y = $urandom_range(0, 9999);
    if ($urandom_range(9) < 2) begin
      m = MONTH_FEB;
      d = $urandom_range(28, 30);
    end
    t = '{CODE_ZERO + 8'(d / 10), CODE_ZERO + 8'(d % 10), CODE_SLASH,
          CODE_ZERO + 8'(m / 10), CODE_ZERO + 8'(m % 10), CODE_SLASH,
          CODE_ZERO + 8'(y / 1000), CODE_ZERO + 8'(y / 100 % 10),
          CODE_ZERO + 8'(y / 10 % 10), CODE_ZERO + 8'(y % 10)};
    kind = $urandom_range(99);
    if (kind < 70) begin
      // keep it well formed
    end else if (kind < 78) begin
      t[$urandom_range(9)] = 8'($urandom_range(255));
    end else if (kind < 85) begin
      n = $urandom_range(1, 9);
      while (t.size() > n) void'(t.pop_back());
    end else if (kind < 92) begin
      repeat ($urandom_range(1, 4)) t.push_back(8'($urandom_range(255)));
    end else begin
      t.delete();
      repeat ($urandom_range(1, 14)) t.push_back(8'($urandom_range(255)));
    end
  endtask

  // Receiver: random stalls, plus one long hold on request.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go  = 1'b0;
        hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  // Result checker: every word against the oldest pending expectation.
  always @(posedge clk) begin
    date_word_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_dates.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: result word with nothing pending: %h", $realtime, got);
      end else begin
        want = pending_dates.pop_front();
        if (got.fmt_ok !== want.fmt_ok || got.valid !== want.valid ||
            got.day !== want.day || got.month !== want.month ||
            got.year !== want.year || got.pad !== want.pad) begin
          fails++;
          if (fails <= 10)
            $display({"%0t: want fmt=%0b ok=%0b %0d/%0d/%0d pad=%0d, ",
                      "got fmt=%0b ok=%0b %0d/%0d/%0d pad=%0d"},
                     $realtime, want.fmt_ok, want.valid, want.day, want.month,
                     want.year, want.pad, got.fmt_ok, got.valid, got.day,
                     got.month, got.year, got.pad);
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [CHAR_W-1:0] t [$];
    logic [CHAR_W-1:0] c;
    date_word_t        tab_w;
    int                n_sent;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    n_sent   = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    src_idle = 25;
    snk_idle = 88;

    // directed texts
    for (int r = 0; r < DIR_N; r++) begin
      t.delete();
      for (int i = 0; i < dir_txt[r].len(); i++) begin
        c = dir_txt[r].getc(i);
        t.push_back(c == "#" ? 8'h00 : c);
      end
      tab_w        = '0;
      tab_w.fmt_ok = dir_want[r][0][0];
      tab_w.valid  = dir_want[r][1][0];
      tab_w.day    = DAY_W'(dir_want[r][2]);
      tab_w.month  = MONTH_W'(dir_want[r][3]);
      tab_w.year   = YEAR_W'(dir_want[r][4]);
      n_sent += t.size();
      send_text(t, dir_want[r][0] != PREDICT, tab_w);
    end

    // random phases; the sender drains the results between them
    for (int ph = 0; ph < 3; ph++) begin
      src_idle = (ph == 0) ? 25 : (ph == 1) ? 88 : 0;
      snk_idle = (ph == 0) ? 88 : (ph == 1) ? 25 : 0;
      if (ph == 2) hold_go = 1'b1;  // back up the block while words keep coming
      while (n_sent < (ph + 1) * PHASE_CH) begin
        make_text(t);
        n_sent += t.size();
        send_text(t, 1'b0, '0);
      end
      s_tvalid <= 1'b0;
      while (pending_dates.size() != 0) @(negedge clk);
      @(negedge clk);
    end

    repeat (10) @(posedge clk);
    if (fails == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
